// File: rtl/gpio_pkg.sv
`timescale 1ns / 1ps

package gpio_pkg;

   // Fixed widths of the bus fields and sizes of the register layout.
   localparam int FIELD_W       = 54;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 4;
   localparam int SEL_W         = 3;
   localparam int PINS_PER_WORD = 10;
   localparam int FSEL_WORDS    = 6;
   localparam int FSEL_IDX_W    = 3;
   localparam int LATCH_W       = 64;

   // Access kinds.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Register word indexes.
   localparam logic [INDEX_W-1:0] REG_FSEL_FIRST = 4'd0;
   localparam logic [INDEX_W-1:0] REG_FSEL_LAST  = 4'd5;
   localparam logic [INDEX_W-1:0] REG_SET0       = 4'd7;
   localparam logic [INDEX_W-1:0] REG_SET1       = 4'd8;
   localparam logic [INDEX_W-1:0] REG_CLR0       = 4'd10;
   localparam logic [INDEX_W-1:0] REG_CLR1       = 4'd11;
   localparam logic [INDEX_W-1:0] REG_LEV0       = 4'd13;
   localparam logic [INDEX_W-1:0] REG_LEV1       = 4'd14;

   // Function select codes.
   localparam logic [SEL_W-1:0] FSEL_OUTPUT = 3'b001;
   localparam logic [SEL_W-1:0] FSEL_MASK   = 3'b111;

   // One bus access.
   typedef struct packed {
      logic                 cmd;
      logic [INDEX_W-1:0]   reg_index;
      logic [DATA_W-1:0]    write_word;
      logic [FIELD_W-1:0]   pin_levels;
   } req_type;

   // One access result.
   typedef struct packed {
      logic [DATA_W-1:0]    read_word;
      logic [FIELD_W-1:0]   drive_value;
      logic [FIELD_W-1:0]   drive_enable;
   } rsp_type;

endpackage

// File: rtl/gpio_if.sv
`timescale 1ns / 1ps

// Request channel: one bus access per transfer.
interface gpio_req_if;
   import gpio_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Response channel: one result per access.
interface gpio_rsp_if;
   import gpio_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/gpio_function_select_set_clear_block.sv
`timescale 1ns / 1ps

// GPIO register block on a 32-bit register bus. Each request is one read or
// write of a word register (function selects at words 0 to 5, set at 7 and 8,
// clear at 10 and 11, levels at 13 and 14) with the sampled pin levels
// attached, and each request returns exactly one response holding the read
// data, the output latch and the per-pin output enables after that access.
// The block takes one request every clock cycle while responses are taken.
// A request is held in the request register, the register update is done as
// it moves on to the response register, and the response waits there until
// it is taken. A response that is held back stalls the request side once both
// registers are full.
// Unmapped words and pins at or above PIN_COUNT read zero and ignore writes.
module gpio_function_select_set_clear_block #(
   parameter int PIN_COUNT = 54
) (
   input  logic            clock,
   input  logic            reset,
   gpio_req_if.sink        req_if,
   gpio_rsp_if.source      rsp_if
);
   import gpio_pkg::*;

   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    advance;

   // A held request moves on when the response register is free or drains.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;

   gpio_regs #(
      .PIN_COUNT (PIN_COUNT)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .access (req_data_ff),
      .result (rsp_data_in)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         req_data_ff <= req_if.data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

// File: rtl/gpio_regs.sv
`timescale 1ns / 1ps

module gpio_regs #(
   parameter int PIN_COUNT = 54
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  gpio_pkg::req_type access,
   output gpio_pkg::rsp_type result
);
   import gpio_pkg::*;

   logic [SEL_W-1:0]     fsel_ff [PIN_COUNT];
   wire  [SEL_W-1:0]     fsel_in [PIN_COUNT];
   logic [PIN_COUNT-1:0] latch_ff;
   logic [PIN_COUNT-1:0] latch_in;
   wire  [PIN_COUNT-1:0] enable_cur;
   wire  [PIN_COUNT-1:0] enable_nxt;
   wire  [DATA_W-1:0]    sel_word [FSEL_WORDS];
   logic [LATCH_W-1:0]   wide_mask;
   logic [PIN_COUNT-1:0] pin_mask;
   logic [PIN_COUNT-1:0] ext_level;
   logic [LATCH_W-1:0]   level_wide;
   logic [DATA_W-1:0]    read_word;
   logic                 is_write;

   assign is_write = (access.cmd == CMD_WRITE);

   // Per-pin function select update and output enable decode.
   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
      localparam logic [INDEX_W-1:0] WORD = INDEX_W'(p / PINS_PER_WORD);
      localparam int LSB = SEL_W * (p % PINS_PER_WORD);

      assign fsel_in[p] = (is_write && access.reg_index == WORD)
                          ? (access.write_word[LSB +: SEL_W] & FSEL_MASK)
                          : fsel_ff[p];
      assign enable_cur[p] = (fsel_ff[p] == FSEL_OUTPUT);
      assign enable_nxt[p] = (fsel_in[p] == FSEL_OUTPUT);
   end

   // Read view of the select words; missing pins and spare bits read zero.
   for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_word
      for (genvar k = 0; k < PINS_PER_WORD; k++) begin : g_field
         if (w * PINS_PER_WORD + k < PIN_COUNT) begin : g_used
            assign sel_word[w][SEL_W*k +: SEL_W] = fsel_ff[w * PINS_PER_WORD + k];
         end else begin : g_unused
            assign sel_word[w][SEL_W*k +: SEL_W] = '0;
         end
      end
      assign sel_word[w][DATA_W-1:SEL_W*PINS_PER_WORD] = '0;
   end

   // Set and clear masks aligned to the pin range.
   always_comb begin
      wide_mask = LATCH_W'(access.write_word);
      if (access.reg_index == REG_SET1 || access.reg_index == REG_CLR1) begin
         wide_mask = {access.write_word, {(LATCH_W-DATA_W){1'b0}}};
      end
      pin_mask = wide_mask[PIN_COUNT-1:0];
   end

   // Output latch next value.
   always_comb begin
      latch_in = latch_ff;
      if (is_write) begin
         case (access.reg_index) inside
            REG_SET0, REG_SET1: latch_in = latch_ff | pin_mask;
            REG_CLR0, REG_CLR1: latch_in = latch_ff & ~pin_mask;
            default:            latch_in = latch_ff;
         endcase
      end
   end

   // Pin level view: latch for outputs, external level otherwise.
   always_comb begin
      ext_level  = PIN_COUNT'(LATCH_W'(access.pin_levels));
      level_wide = LATCH_W'((latch_ff & enable_cur) | (ext_level & ~enable_cur));
   end

   // Read data decode.
   always_comb begin
      read_word = '0;
      if (!is_write) begin
         unique case (access.reg_index) inside
            [REG_FSEL_FIRST:REG_FSEL_LAST]:
               read_word = sel_word[access.reg_index[FSEL_IDX_W-1:0]];
            REG_LEV0: read_word = level_wide[DATA_W-1:0];
            REG_LEV1: read_word = level_wide[LATCH_W-1:DATA_W];
            default:  read_word = '0;
         endcase
      end
   end

   // Result reflects the state after this access.
   always_comb begin
      result.read_word    = read_word;
      result.drive_value  = FIELD_W'(LATCH_W'(latch_in));
      result.drive_enable = FIELD_W'(LATCH_W'(enable_nxt));
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
         for (int p = 0; p < PIN_COUNT; p++) begin
            fsel_ff[p] <= '0;
         end
      end else if (update) begin
         latch_ff <= latch_in;
         for (int p = 0; p < PIN_COUNT; p++) begin
            fsel_ff[p] <= fsel_in[p];
         end
      end
   end

endmodule

// File: tb/sv/tb_gpio_function_select_set_clear_block.sv
`timescale 1ns / 1ps

module tb_gpio_function_select_set_clear_block;
   import gpio_pkg::*;

   localparam int PIN_TOTAL   = 54;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 20;

   // Word indexes that decode to no register.
   localparam logic [INDEX_W-1:0] REG_HOLE_6  = 4'd6;
   localparam logic [INDEX_W-1:0] REG_HOLE_9  = 4'd9;
   localparam logic [INDEX_W-1:0] REG_HOLE_12 = 4'd12;
   localparam logic [INDEX_W-1:0] REG_HOLE_15 = 4'd15;

   // Select word with code 001 in all ten slots and stray bit 30 set.
   localparam logic [DATA_W-1:0] ALL_OUTPUT_WORD = 32'h4924_9249;
   localparam logic [DATA_W-1:0] ONES_WORD       = '1;
   localparam logic [FIELD_W-1:0] ONES_LEVELS    = '1;

   logic clock;
   logic reset;

   gpio_req_if req_ch ();
   gpio_rsp_if rsp_ch ();

   gpio_function_select_set_clear_block #(
      .PIN_COUNT(PIN_TOTAL)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow copy of the register state, updated as requests are taken.
   logic [SEL_W-1:0]   pin_func_sel [PIN_TOTAL];
   logic [FIELD_W-1:0] pin_out_latch;

   rsp_type awaited_results [$];

   int  mismatch_count;
   int  cycle_count;
   int  reads_sent;
   int  writes_sent;
   int  results_checked;
   int  hold_off_len;
   bit  sender_gaps;
   bit  quiet_phase;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Per-pin output enables from the shadow selects.
   function automatic logic [FIELD_W-1:0] output_enables();
      logic [FIELD_W-1:0] en;
      en = '0;
      for (int n = 0; n < PIN_TOTAL; n++) begin
         if (pin_func_sel[n] == FSEL_OUTPUT) begin
            en[n] = 1'b1;
         end
      end
      return en;
   endfunction

   // Apply one request to the shadow state and return the response it yields.
   function automatic rsp_type gpio_access_outcome(req_type r);
      rsp_type            res;
      logic [FIELD_W-1:0] mask;
      logic [FIELD_W-1:0] en;
      logic [FIELD_W-1:0] lev;
      int                 pin;
      res.read_word = '0;
      if (r.reg_index == REG_SET0 || r.reg_index == REG_CLR0) begin
         mask = {{(FIELD_W-DATA_W){1'b0}}, r.write_word};
      end else begin
         mask = {r.write_word[FIELD_W-DATA_W-1:0], {DATA_W{1'b0}}};
      end
      if (r.cmd == CMD_WRITE) begin
         if (r.reg_index <= REG_FSEL_LAST) begin
            for (int k = 0; k < PINS_PER_WORD; k++) begin
               pin = int'(r.reg_index) * PINS_PER_WORD + k;
               if (pin < PIN_TOTAL) begin
                  pin_func_sel[pin] = r.write_word[SEL_W*k +: SEL_W];
               end
            end
         end else if (r.reg_index == REG_SET0 || r.reg_index == REG_SET1) begin
            pin_out_latch = pin_out_latch | mask;
         end else if (r.reg_index == REG_CLR0 || r.reg_index == REG_CLR1) begin
            pin_out_latch = pin_out_latch & ~mask;
         end
      end else begin
         if (r.reg_index <= REG_FSEL_LAST) begin
            for (int k = 0; k < PINS_PER_WORD; k++) begin
               pin = int'(r.reg_index) * PINS_PER_WORD + k;
               if (pin < PIN_TOTAL) begin
                  res.read_word[SEL_W*k +: SEL_W] = pin_func_sel[pin];
               end
            end
         end else if (r.reg_index == REG_LEV0 || r.reg_index == REG_LEV1) begin
            en  = output_enables();
            lev = (pin_out_latch & en) | (r.pin_levels & ~en);
            if (r.reg_index == REG_LEV1) begin
               res.read_word = {{(2*DATA_W-FIELD_W){1'b0}}, lev[FIELD_W-1:DATA_W]};
            end else begin
               res.read_word = lev[DATA_W-1:0];
            end
         end
      end
      res.drive_value  = pin_out_latch;
      res.drive_enable = output_enables();
      return res;
   endfunction

   function automatic req_type make_access(logic cmd, logic [INDEX_W-1:0] idx,
                                           logic [DATA_W-1:0] word,
                                           logic [FIELD_W-1:0] levels);
      req_type r;
      r.cmd        = cmd;
      r.reg_index  = idx;
      r.write_word = word;
      r.pin_levels = levels;
      return r;
   endfunction

   function automatic logic [FIELD_W-1:0] random_levels();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[FIELD_W-1:0];
   endfunction

   // Random data word, with all zeros and all ones mixed in.
   function automatic logic [DATA_W-1:0] random_data();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ONES_WORD;
         default: return $urandom;
      endcase
   endfunction

   // Select word with many output codes so that level reads show the latch.
   function automatic logic [DATA_W-1:0] random_select_word();
      logic [DATA_W-1:0] w;
      w = '0;
      for (int k = 0; k < PINS_PER_WORD; k++) begin
         if ($urandom_range(0, 1) == 1) begin
            w[SEL_W*k +: SEL_W] = FSEL_OUTPUT;
         end else begin
            w[SEL_W*k +: SEL_W] = SEL_W'($urandom_range(0, 7));
         end
      end
      w[DATA_W-1:DATA_W-2] = 2'($urandom_range(0, 3));
      return w;
   endfunction

   // Mostly well-formed register traffic, with some fully random requests.
   function automatic req_type random_access();
      int                 pick;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         idx = INDEX_W'(REG_FSEL_FIRST + $urandom_range(0, FSEL_WORDS - 1));
         return make_access(CMD_WRITE, idx, random_select_word(), random_levels());
      end else if (pick < 38) begin
         case ($urandom_range(0, 3))
            0: idx = REG_SET0;
            1: idx = REG_SET1;
            2: idx = REG_CLR0;
            default: idx = REG_CLR1;
         endcase
         return make_access(CMD_WRITE, idx, random_data(), random_levels());
      end else if (pick < 62) begin
         idx = ($urandom_range(0, 1) == 1) ? REG_LEV1 : REG_LEV0;
         return make_access(CMD_READ, idx, random_data(), random_levels());
      end else if (pick < 76) begin
         idx = INDEX_W'(REG_FSEL_FIRST + $urandom_range(0, FSEL_WORDS - 1));
         return make_access(CMD_READ, idx, random_data(), random_levels());
      end
      idx = INDEX_W'($urandom_range(0, 15));
      return make_access(1'($urandom_range(0, 1)), idx, random_data(), random_levels());
   endfunction

   // Offer one request, with an optional idle burst first, and wait until it is taken.
   task automatic send_access(input req_type r);
      if (sender_gaps && !quiet_phase && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      awaited_results.push_back(gpio_access_outcome(r));
      if (r.cmd == CMD_WRITE) begin
         writes_sent++;
      end else begin
         reads_sent++;
      end
   endtask

   task automatic wait_for_results();
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      end
   endtask

   // Extremes of every field, each register kind and the ignored cases.
   task automatic test_directed();
      logic [INDEX_W-1:0] idx;
      send_access(make_access(CMD_READ, REG_LEV0, '0, ONES_LEVELS));
      send_access(make_access(CMD_READ, REG_LEV1, ONES_WORD, ONES_LEVELS));
      for (int w = 0; w < FSEL_WORDS - 1; w++) begin
         idx = INDEX_W'(REG_FSEL_FIRST + w);
         send_access(make_access(CMD_WRITE, idx, ALL_OUTPUT_WORD, '0));
      end
      // The last select word only holds four pins; the rest must read zero.
      send_access(make_access(CMD_WRITE, REG_FSEL_LAST, ONES_WORD, '0));
      send_access(make_access(CMD_READ, REG_FSEL_LAST, '0, '0));
      send_access(make_access(CMD_WRITE, REG_FSEL_LAST, ALL_OUTPUT_WORD, '0));
      send_access(make_access(CMD_WRITE, REG_SET0, ONES_WORD, '0));
      send_access(make_access(CMD_WRITE, REG_SET1, ONES_WORD, '0));
      send_access(make_access(CMD_READ, REG_LEV1, '0, '0));
      send_access(make_access(CMD_WRITE, REG_CLR0, 32'hAAAA_AAAA, ONES_LEVELS));
      send_access(make_access(CMD_WRITE, REG_CLR1, ONES_WORD, ONES_LEVELS));
      send_access(make_access(CMD_READ, REG_LEV0, '0, random_levels()));
      // Set and clear words read zero; unmapped and level writes are ignored.
      send_access(make_access(CMD_READ, REG_SET0, '0, '0));
      send_access(make_access(CMD_READ, REG_CLR1, '0, '0));
      send_access(make_access(CMD_WRITE, REG_HOLE_6, ONES_WORD, '0));
      send_access(make_access(CMD_WRITE, REG_HOLE_15, ONES_WORD, '0));
      send_access(make_access(CMD_WRITE, REG_LEV0, ONES_WORD, '0));
      send_access(make_access(CMD_READ, REG_HOLE_9, '0, ONES_LEVELS));
      send_access(make_access(CMD_READ, REG_HOLE_12, '0, ONES_LEVELS));
      // Pins 20 to 29 back to input, so their levels come from outside.
      send_access(make_access(CMD_WRITE, INDEX_W'(REG_FSEL_FIRST + 2), '0, '0));
      send_access(make_access(CMD_READ, REG_LEV0, '0, ONES_LEVELS));
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         send_access(random_access());
      end
   endtask

   // Receiver holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_off_len = 60;
      for (int i = 0; i < 30; i++) begin
         send_access(random_access());
      end
      req_ch.valid <= 1'b0;
      wait_for_results();
   endtask

   // Result checking and the cycle limit.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result with no request pending",
                            64'(rsp_ch.data.read_word), '0);
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (rsp_ch.data.read_word !== want.read_word) begin
               report_mismatch("read_word", 64'(rsp_ch.data.read_word),
                               64'(want.read_word));
            end
            if (rsp_ch.data.drive_value !== want.drive_value) begin
               report_mismatch("drive_value", 64'(rsp_ch.data.drive_value),
                               64'(want.drive_value));
            end
            if (rsp_ch.data.drive_enable !== want.drive_enable) begin
               report_mismatch("drive_enable", 64'(rsp_ch.data.drive_enable),
                               64'(want.drive_enable));
            end
         end
      end
   end

   // Response ready: a long hold when asked, always ready in the quiet phase, else random stall bursts.
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len > 0) begin
            hold_left    = hold_off_len;
            hold_off_len = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet_phase) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Test sequence.
   initial begin
      mismatch_count  = 0;
      cycle_count     = 0;
      reads_sent      = 0;
      writes_sent     = 0;
      results_checked = 0;
      hold_off_len    = 0;
      sender_gaps     = 1'b0;
      quiet_phase     = 1'b0;
      pin_out_latch   = '0;
      for (int n = 0; n < PIN_TOTAL; n++) begin
         pin_func_sel[n] = '0;
      end
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      sender_gaps = 1'b1;
      test_random_traffic(700);
      test_backpressure();
      test_random_traffic(700);
      quiet_phase = 1'b1;
      test_random_traffic(300);
      req_ch.valid <= 1'b0;

      wait_for_results();
      repeat (5) @(posedge clock);

      $display("Sent %0d reads and %0d writes over all register words, with idle bursts,",
               reads_sent, writes_sent);
      $display("a long response hold-off and a stretch at full rate; %0d results checked.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
